[rtl/mfq_pkg.sv]
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types and constants for the MJPEG frame qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mfq_pkg;

    localparam int LEN_W   = 24;
    localparam int CNT_W   = 32;
    localparam int TOTAL_W = 64;
    localparam int DIM_W   = 12;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // action codes
    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_EMPTY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] FMT_MJPEG = 3'd0;

    // marker bytes
    localparam logic [7:0] MARK_FF  = 8'hFF;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_EOI = 8'hD9;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_JPEG      = 2'd2;

    localparam logic [DIM_W-1:0] RST_TARGET_WIDTH  = 12'd1280;
    localparam logic [DIM_W-1:0] RST_TARGET_HEIGHT = 12'd720;
    localparam logic [LEN_W-1:0] RST_MAX_JPEG      = 24'd524288;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       byte_value;
        logic             last_byte;
        logic [2:0]       format_code;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } item_t;

    typedef struct packed {
        logic               frame_complete;
        logic [LEN_W-1:0]   jpeg_length;
        logic [LEN_W-1:0]   frame_length;
        logic [CNT_W-1:0]   frames_seen;
        logic [CNT_W-1:0]   target_count;
        logic [CNT_W-1:0]   complete_count;
        logic [CNT_W-1:0]   missing_start_frames;
        logic [CNT_W-1:0]   missing_end_frames;
        logic [CNT_W-1:0]   oversized_count;
        logic [CNT_W-1:0]   empty_count;
        logic [TOTAL_W-1:0] byte_total;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0] target_width;
        logic [DIM_W-1:0] target_height;
        logic [LEN_W-1:0] max_jpeg_bytes;
    } cfg_t;

    // per-beat verdict from the frame tracker to the statistics block
    typedef struct packed {
        logic             emit;
        logic             frame_end;
        logic             empty;
        logic             clear;
        logic             target;
        logic             done;
        logic             has_start;
        logic             has_end;
        logic             oversized;
        logic [LEN_W-1:0] jpeg_length;
        logic [LEN_W-1:0] frame_length;
    } status_t;

endpackage

`default_nettype wire

[rtl/mfq_regs.sv]
// ----------------------------------------------------------------------------
// mfq_regs
// APB register file: target width, target height and size limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mfq_pkg::APB_AW-1:0] paddr,
    input  logic [mfq_pkg::APB_DW-1:0] pwdata,
    output logic [mfq_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output mfq_pkg::cfg_t              cfg
);
    import mfq_pkg::*;

    logic [DIM_W-1:0] target_width_reg;
    logic [DIM_W-1:0] target_height_reg;
    logic [LEN_W-1:0] max_jpeg_reg;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_width_reg  <= RST_TARGET_WIDTH;
            target_height_reg <= RST_TARGET_HEIGHT;
            max_jpeg_reg      <= RST_MAX_JPEG;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET_WIDTH:  target_width_reg  <= pwdata[DIM_W-1:0];
                REG_TARGET_HEIGHT: target_height_reg <= pwdata[DIM_W-1:0];
                REG_MAX_JPEG:      max_jpeg_reg      <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TARGET_WIDTH:  prdata = APB_DW'(target_width_reg);
            REG_TARGET_HEIGHT: prdata = APB_DW'(target_height_reg);
            REG_MAX_JPEG:      prdata = APB_DW'(max_jpeg_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.target_width   = target_width_reg;
    assign cfg.target_height  = target_height_reg;
    assign cfg.max_jpeg_bytes = max_jpeg_reg;

`ifndef SYNTHESIS
    a_wr_width: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && reg_idx == REG_TARGET_WIDTH)
        |=> target_width_reg == $past(pwdata[DIM_W-1:0]))
        else $error("target width write lost");

    a_wr_max: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && reg_idx == REG_MAX_JPEG)
        |=> max_jpeg_reg == $past(pwdata[LEN_W-1:0]))
        else $error("size limit write lost");

    a_no_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_en |=> $stable(target_height_reg) && $stable(max_jpeg_reg))
        else $error("config changed without a write");
`endif

endmodule

`default_nettype wire

[rtl/mfq_frame.sv]
// ----------------------------------------------------------------------------
// mfq_frame
// Per-frame tracker: byte position, start/end marker search and verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  mfq_pkg::item_t   item,
    input  mfq_pkg::cfg_t    cfg,
    output mfq_pkg::status_t status
);
    import mfq_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic [LEN_W-1:0] pos_reg;
    logic             start_ok_reg;
    logic             prev_ff_reg;
    logic [LEN_W-1:0] end_pos_reg;

    logic             is_data;
    logic             is_empty;
    logic             frame_end;
    logic [LEN_W-1:0] flen;
    logic             start_ok_next;
    logic [LEN_W-1:0] end_pos_next;
    logic             target;
    logic             oversized;
    logic             has_start;
    logic             has_end;
    logic [LEN_W-1:0] jlen;

    always_comb
    begin
        is_data   = (item.action == ACT_DATA);
        is_empty  = (item.action == ACT_EMPTY);
        frame_end = is_data && item.last_byte;

        // length saturates at all ones
        flen = (pos_reg == LEN_MAX) ? pos_reg : pos_reg + 1'b1;

        if (pos_reg == '0)
            start_ok_next = (item.byte_value == MARK_FF);
        else if (pos_reg == LEN_W'(1))
            start_ok_next = start_ok_reg && (item.byte_value == MARK_SOI);
        else
            start_ok_next = start_ok_reg;

        end_pos_next = (prev_ff_reg && item.byte_value == MARK_EOI) ? flen : end_pos_reg;

        target    = (item.format_code == FMT_MJPEG)
                    && (item.frame_width == cfg.target_width)
                    && (item.frame_height == cfg.target_height);
        oversized = target && (flen > cfg.max_jpeg_bytes);
        has_start = target && (flen >= LEN_W'(2)) && start_ok_next;
        jlen      = target ? end_pos_next : '0;
        has_end   = (jlen != '0);
    end

    always_comb
    begin
        status.emit         = frame_end || is_empty;
        status.frame_end    = frame_end;
        status.empty        = is_empty;
        status.clear        = (item.action == ACT_CLEAR);
        status.target       = target;
        status.done         = target && !oversized && has_start && has_end;
        status.has_start    = has_start;
        status.has_end      = has_end;
        status.oversized    = oversized;
        status.jpeg_length  = jlen;
        status.frame_length = flen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            start_ok_reg <= 1'b0;
            prev_ff_reg  <= 1'b0;
            end_pos_reg  <= '0;
        end
        else if (accept)
        begin
            if (is_data && !item.last_byte)
            begin
                pos_reg      <= flen;
                start_ok_reg <= start_ok_next;
                prev_ff_reg  <= (item.byte_value == MARK_FF);
                end_pos_reg  <= end_pos_next;
            end
            else if (frame_end || is_empty)
            begin
                pos_reg      <= '0;
                start_ok_reg <= 1'b0;
                prev_ff_reg  <= 1'b0;
                end_pos_reg  <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (frame_end || is_empty))
        |=> pos_reg == '0 && end_pos_reg == '0 && !prev_ff_reg)
        else $error("frame state not cleared at frame end");

    a_end_within_frame: assert property (@(posedge clk) disable iff (!rst_n)
        end_pos_reg <= pos_reg)
        else $error("end marker beyond current position");

    a_start_needs_ff: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_data && !item.last_byte && pos_reg == '0
         && item.byte_value != MARK_FF) |=> !start_ok_reg)
        else $error("start flag set without leading ff");
`endif

endmodule

`default_nettype wire

[rtl/mfq_stats.sv]
// ----------------------------------------------------------------------------
// mfq_stats
// Statistics counters and result register with its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_stats (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  mfq_pkg::status_t status,
    input  logic             result_ready,
    output logic             result_valid,
    output mfq_pkg::result_t result
);
    import mfq_pkg::*;

    localparam int NUM_CNT      = 7;
    localparam int CNT_FRAMES   = 0;
    localparam int CNT_TARGET   = 1;
    localparam int CNT_COMPLETE = 2;
    localparam int CNT_NO_START = 3;
    localparam int CNT_NO_END   = 4;
    localparam int CNT_OVERSIZE = 5;
    localparam int CNT_EMPTY    = 6;

    // counters double as the result payload: nothing is accepted while a
    // result waits, so they cannot move under a stalled beat
    logic [CNT_W-1:0]   cnt_reg   [NUM_CNT];
    logic [CNT_W-1:0]   cnt_next  [NUM_CNT];
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [NUM_CNT-1:0] inc;
    logic               valid_reg;
    logic               done_reg;
    logic [LEN_W-1:0]   jlen_reg;
    logic [LEN_W-1:0]   flen_reg;

    always_comb
    begin
        inc               = '0;
        inc[CNT_FRAMES]   = status.frame_end;
        inc[CNT_TARGET]   = status.frame_end && status.target;
        inc[CNT_COMPLETE] = status.frame_end && status.done;
        inc[CNT_NO_START] = status.frame_end && status.target && !status.has_start;
        inc[CNT_NO_END]   = status.frame_end && status.target && !status.has_end;
        inc[CNT_OVERSIZE] = status.frame_end && status.oversized;
        inc[CNT_EMPTY]    = status.empty;

        for (int k = 0; k < NUM_CNT; k++)
            cnt_next[k] = status.clear ? '0 : cnt_reg[k] + CNT_W'(inc[k]);

        if (status.clear)
            total_next = '0;
        else if (status.frame_end)
            total_next = total_reg + TOTAL_W'(status.frame_length);
        else
            total_next = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CNT; k++)
                cnt_reg[k] <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int k = 0; k < NUM_CNT; k++)
                    cnt_reg[k] <= cnt_next[k];
                total_reg <= total_next;
            end
            if (accept && status.emit)
                valid_reg <= 1'b1;
            else if (result_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && status.emit)
        begin
            done_reg <= status.frame_end && status.done;
            jlen_reg <= status.frame_end ? status.jpeg_length : '0;
            flen_reg <= status.frame_end ? status.frame_length : '0;
        end
    end

    assign result_valid                = valid_reg;
    assign result.frame_complete       = done_reg;
    assign result.jpeg_length          = jlen_reg;
    assign result.frame_length         = flen_reg;
    assign result.frames_seen          = cnt_reg[CNT_FRAMES];
    assign result.target_count         = cnt_reg[CNT_TARGET];
    assign result.complete_count       = cnt_reg[CNT_COMPLETE];
    assign result.missing_start_frames = cnt_reg[CNT_NO_START];
    assign result.missing_end_frames   = cnt_reg[CNT_NO_END];
    assign result.oversized_count      = cnt_reg[CNT_OVERSIZE];
    assign result.empty_count          = cnt_reg[CNT_EMPTY];
    assign result.byte_total           = total_reg;

`ifndef SYNTHESIS
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.emit) |=> valid_reg)
        else $error("result beat not raised");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.clear)
        |=> cnt_reg[CNT_FRAMES] == '0 && cnt_reg[CNT_EMPTY] == '0 && total_reg == '0)
        else $error("statistics not cleared");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.empty)
        |=> cnt_reg[CNT_EMPTY] == CNT_W'($past(cnt_reg[CNT_EMPTY]) + 1'b1))
        else $error("empty frame not counted");

    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_ready) |-> !accept)
        else $error("item taken while result stalled");
`endif

endmodule

`default_nettype wire

[rtl/mjpeg_frame_qualifier_top.sv]
// ----------------------------------------------------------------------------
// mjpeg_frame_qualifier_top
// Latency: a result beat is valid the cycle after its closing item is taken.
// Throughput: one item per cycle; ready drops only while a result is stalled.
// The single result register, shared with the statistics counters, sets this.
// Reset clears frame state, counters and valid; config returns to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mjpeg_frame_qualifier_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mfq_pkg::APB_AW-1:0] paddr,
    input  logic [mfq_pkg::APB_DW-1:0] pwdata,
    output logic [mfq_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  mfq_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output mfq_pkg::result_t           result
);
    import mfq_pkg::*;

    cfg_t    cfg;
    status_t status;
    logic    accept;

    assign item_ready = !result_valid || result_ready;
    assign accept     = item_valid && item_ready;

    mfq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfq_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .status (status)
    );

    mfq_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .status       (status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
